// ===== src/qtwc_pkg.sv =====
`default_nettype none
package qtwc_pkg;

  localparam int NUM_BINS    = 8;
  localparam int NUM_CHOICES = 4;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int CHOICE_W    = $clog2(NUM_CHOICES);
  localparam int ADDR_W      = BIN_W + CHOICE_W;
  localparam int WIN_W       = 31;
  localparam int VAL_W       = 32;
  localparam int DRAW_W      = 8;
  localparam int THR_W       = 9;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [WIN_W-1:0] HALVE_LIMIT   = 31'd60000;
  localparam logic [VAL_W-1:0] BIG_STEP      = 32'd1000;
  localparam logic [THR_W-1:0] EXPLORE_RESET = 9'd205;
  localparam logic [1:0]       COUNT_FULL    = 2'd2;

  localparam logic REG_TRAINING  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef enum logic {
    OP_UPDATE,
    OP_PRELOAD
  } op_t;

  typedef enum logic [CHOICE_W-1:0] {
    ACT_HOLD,
    ACT_INC,
    ACT_STEP,
    ACT_SCALE
  } act_t;

  typedef struct packed {
    op_t                      operation;
    logic [WIN_W-1:0]         window_bytes;
    logic [DRAW_W-1:0]        random_draw;
    logic [CHOICE_W-1:0]      random_action;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [VAL_W-1:0]  entry_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_window;
    act_t             chosen_action;
    logic [BIN_W-1:0] state_bin;
    logic             explored;
  } rsp_t;

  typedef struct packed {
    logic             training_enable;
    logic [THR_W-1:0] explore_threshold;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } tbl_wr_t;

  typedef logic [NUM_CHOICES-1:0][VAL_W-1:0] row_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [WIN_W-1:0] w);
    logic [BIN_W-1:0] b;
    priority if (w < 31'd20000) begin
      b = 3'd0;
    end else if (w < 31'd30000) begin
      b = 3'd1;
    end else if (w < 31'd40000) begin
      b = 3'd2;
    end else if (w < 31'd45000) begin
      b = 3'd3;
    end else if (w < 31'd50000) begin
      b = 3'd4;
    end else if (w < 31'd55000) begin
      b = 3'd5;
    end else if (w < 31'd60000) begin
      b = 3'd6;
    end else begin
      b = 3'd7;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/qtwc_regs.sv =====
`default_nettype none
module qtwc_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [qtwc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [qtwc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [qtwc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output qtwc_pkg::cfg_t                         cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.training_enable   <= 1'b0;
      cfg.explore_threshold <= qtwc_pkg::EXPLORE_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        qtwc_pkg::REG_TRAINING:  cfg.training_enable   <= pwdata[0];
        qtwc_pkg::REG_THRESHOLD: cfg.explore_threshold <= pwdata[qtwc_pkg::THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      qtwc_pkg::REG_TRAINING:  prdata[0] = cfg.training_enable;
      qtwc_pkg::REG_THRESHOLD: prdata[qtwc_pkg::THR_W-1:0] = cfg.explore_threshold;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/qtwc_table.sv =====
`default_nettype none
module qtwc_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qtwc_pkg::tbl_wr_t             wr,
  input  wire logic [qtwc_pkg::BIN_W-1:0]    rd_bin,
  output qtwc_pkg::row_t                     row
);

  qtwc_pkg::row_t rows [qtwc_pkg::NUM_BINS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qtwc_pkg::NUM_BINS; i++) begin
        rows[i] <= '0;
      end
    end else if (wr.en) begin
      rows[wr.addr[qtwc_pkg::ADDR_W-1:qtwc_pkg::CHOICE_W]]
          [wr.addr[qtwc_pkg::CHOICE_W-1:0]] <= wr.data;
    end
  end

  assign row = rows[rd_bin];

endmodule
`default_nettype wire

// ===== src/qtwc_core.sv =====
`default_nettype none
module qtwc_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qtwc_pkg::cfg_t                cfg,
  input  wire qtwc_pkg::req_t                item,
  input  wire logic                          fire,
  input  wire qtwc_pkg::row_t                row,
  output logic [qtwc_pkg::BIN_W-1:0]         rd_bin,
  output qtwc_pkg::tbl_wr_t                  wr,
  output qtwc_pkg::rsp_t                     result
);

  logic [qtwc_pkg::BIN_W-1:0]    prev_bin;
  logic [qtwc_pkg::CHOICE_W-1:0] prev_choice;
  logic [qtwc_pkg::WIN_W-1:0]    prev_window;
  logic [1:0]                    update_count;

  logic [qtwc_pkg::WIN_W-1:0]    win;
  logic [qtwc_pkg::BIN_W-1:0]    bin;
  logic                          is_update;
  logic                          learn;
  logic [qtwc_pkg::VAL_W-1:0]    diff;
  qtwc_pkg::row_t                entry;
  logic [qtwc_pkg::CHOICE_W-1:0] best;
  logic                          explore;
  qtwc_pkg::act_t                choice;
  logic [qtwc_pkg::VAL_W:0]      wide;
  logic [qtwc_pkg::VAL_W:0]      sum;

  assign win       = (item.window_bytes >= qtwc_pkg::HALVE_LIMIT) ?
                     (item.window_bytes >> 1) : item.window_bytes;
  assign bin       = qtwc_pkg::bin_of(win);
  assign rd_bin    = bin;
  assign is_update = (item.operation == qtwc_pkg::OP_UPDATE);
  assign learn     = cfg.training_enable && (update_count == qtwc_pkg::COUNT_FULL);
  assign diff      = {1'b0, win} - {1'b0, prev_window};
  assign explore   = cfg.training_enable &&
                     ({1'b0, item.random_draw} < cfg.explore_threshold);

  // This item's learning write lands only at the clock edge, after the argmax, so it is forwarded.
  always_comb begin
    for (int c = 0; c < qtwc_pkg::NUM_CHOICES; c++) begin
      entry[c] = (learn && (prev_bin == bin) &&
                  (prev_choice == qtwc_pkg::CHOICE_W'(c))) ? diff : row[c];
    end
  end

  always_comb begin
    best = '0;
    for (int c = 1; c < qtwc_pkg::NUM_CHOICES; c++) begin
      if ($signed(entry[c]) > $signed(entry[best])) begin
        best = qtwc_pkg::CHOICE_W'(c);
      end
    end
  end

  always_comb begin
    choice = explore ? qtwc_pkg::act_t'(item.random_action) : qtwc_pkg::act_t'(best);
    wide   = {2'b00, win};
    unique case (choice)
      qtwc_pkg::ACT_HOLD:  sum = wide;
      qtwc_pkg::ACT_INC:   sum = wide + 33'd1;
      qtwc_pkg::ACT_STEP:  sum = wide + {1'b0, qtwc_pkg::BIG_STEP};
      qtwc_pkg::ACT_SCALE: sum = wide + (wide >> 1);
      default:             sum = wide;
    endcase
  end

  always_comb begin
    result.new_window    = sum[qtwc_pkg::VAL_W] ? '1 : sum[qtwc_pkg::VAL_W-1:0];
    result.chosen_action = choice;
    result.state_bin     = bin;
    result.explored      = explore;
  end

  always_comb begin
    if (!is_update) begin
      wr.en   = fire;
      wr.addr = item.entry_index;
      wr.data = item.entry_value;
    end else begin
      wr.en   = fire && learn;
      wr.addr = {prev_bin, prev_choice};
      wr.data = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_bin     <= '0;
      prev_choice  <= '0;
      prev_window  <= '0;
      update_count <= '0;
    end else if (fire && is_update) begin
      prev_bin    <= bin;
      prev_choice <= choice;
      prev_window <= win;
      if (update_count != qtwc_pkg::COUNT_FULL) begin
        update_count <= update_count + 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    update_count != 2'd3)
    else $error("Update count went past saturation.");

  a_argmax_is_max: assert property (@(posedge clk) disable iff (rst)
    fire && is_update && !explore |->
                 ($signed(entry[choice]) >= $signed(entry[0])) &&
                 ($signed(entry[choice]) >= $signed(entry[1])) &&
                 ($signed(entry[choice]) >= $signed(entry[2])) &&
                 ($signed(entry[choice]) >= $signed(entry[3])))
    else $error("Greedy choice is not a maximum of its row.");

  a_preload_keeps_history: assert property (@(posedge clk) disable iff (rst)
    fire && !is_update |=> $stable(update_count) && $stable(prev_window))
    else $error("Preload beat disturbed the update history.");
`endif

endmodule
`default_nettype wire

// ===== src/q_table_window_controller.sv =====
`default_nettype none
// A window update accepted into the input stage register has its result registered
// in the result register. Throughput: one beat per cycle, update or preload, from one
// compute pass between the two; an update stalls while an untaken result is held.
// Preload beats write the table and return no result.
// Synchronous reset clears the value table, the update history and the valid flags, and resets the config registers.
module q_table_window_controller (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire qtwc_pkg::req_t                  req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output qtwc_pkg::rsp_t                       rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [qtwc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [qtwc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [qtwc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  qtwc_pkg::cfg_t             cfg;
  qtwc_pkg::req_t             stage;
  logic                       stage_valid;
  logic                       advance;
  logic                       stage_update;
  qtwc_pkg::row_t             row;
  logic [qtwc_pkg::BIN_W-1:0] rd_bin;
  qtwc_pkg::tbl_wr_t          tbl_wr;
  qtwc_pkg::rsp_t             result;

  qtwc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qtwc_table u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (tbl_wr),
    .rd_bin (rd_bin),
    .row    (row)
  );

  qtwc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (stage),
    .fire   (advance),
    .row    (row),
    .rd_bin (rd_bin),
    .wr     (tbl_wr),
    .result (result)
  );

  assign stage_update = (stage.operation == qtwc_pkg::OP_UPDATE);
  assign advance      = stage_valid && (!stage_update || !rsp_valid || rsp_ready);
  assign req_ready    = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && stage_update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_update) begin
      rsp <= result;
    end
  end

`ifndef SYNTH
  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && stage_update |=> rsp_valid)
    else $error("Update beat left the stage without a result.");

  a_preload_no_result: assert property (@(posedge clk) disable iff (rst)
    advance && !stage_update && !rsp_valid |=> !rsp_valid)
    else $error("Preload beat produced a result.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("Stalled stage lost or changed its beat.");
`endif

endmodule
`default_nettype wire

// ===== tb/q_table_window_controller_test.sv =====
`default_nettype none
module q_table_window_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qtwc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  req_t req_backlog[$];
  rsp_t due_windows[$];
  int send_gap_pct = 0;
  int hold_off_pct = 0;
  int fail_count = 0;

  logic signed [VAL_W-1:0] value_tbl [NUM_BINS*NUM_CHOICES];
  logic [BIN_W-1:0] last_bin = '0;
  act_t last_act = ACT_HOLD;
  logic [WIN_W-1:0] last_win = '0;
  int hist_count = 0;
  logic train_en = 1'b0;
  logic [THR_W-1:0] thr_level = EXPLORE_RESET;

  q_table_window_controller DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [WIN_W-1:0] bin_floor(input int k);
    case (k)
      1: return 31'd20000;
      2: return 31'd30000;
      3: return 31'd40000;
      4: return 31'd45000;
      5: return 31'd50000;
      6: return 31'd55000;
      default: return 31'd60000;
    endcase
  endfunction

  function automatic logic [BIN_W-1:0] window_bin(input logic [WIN_W-1:0] w);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int k = 1; k < NUM_BINS; k++) begin
      if (w >= bin_floor(k)) b = BIN_W'(k);
    end
    return b;
  endfunction

  function automatic act_t best_action(input logic [BIN_W-1:0] bin);
    int best;
    best = 0;
    for (int c = 1; c < NUM_CHOICES; c++) begin
      if (value_tbl[int'(bin) * NUM_CHOICES + c] > value_tbl[int'(bin) * NUM_CHOICES + best])
        best = c;
    end
    return act_t'(best);
  endfunction

  function automatic void predict_window(input req_t r);
    logic [WIN_W-1:0] w;
    logic [33:0] grown;
    rsp_t e;
    if (r.operation == OP_PRELOAD) begin
      value_tbl[r.entry_index] = r.entry_value;
      return;
    end
    w = (r.window_bytes >= HALVE_LIMIT) ? r.window_bytes >> 1 : r.window_bytes;
    e.state_bin = window_bin(w);
    if (train_en && hist_count >= 2)
      value_tbl[{last_bin, last_act}] = {1'b0, w} - {1'b0, last_win};
    if (train_en && {1'b0, r.random_draw} < thr_level) begin
      e.chosen_action = act_t'(r.random_action);
      e.explored = 1'b1;
    end else begin
      e.chosen_action = best_action(e.state_bin);
      e.explored = 1'b0;
    end
    case (e.chosen_action)
      ACT_INC: grown = 34'(w) + 34'd1;
      ACT_STEP: grown = 34'(w) + 34'(BIG_STEP);
      ACT_SCALE: grown = (34'(w) * 34'd3) >> 1;
      default: grown = 34'(w);
    endcase
    e.new_window = (grown > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    last_bin = e.state_bin;
    last_act = e.chosen_action;
    last_win = w;
    if (hist_count < 2) hist_count++;
    due_windows.push_back(e);
  endfunction

  function automatic req_t update_beat(input logic [WIN_W-1:0] w, input logic [7:0] draw,
                                       input logic [1:0] pick);
    req_t r;
    r = '0;
    r.operation = OP_UPDATE;
    r.window_bytes = w;
    r.random_draw = draw;
    r.random_action = pick;
    return r;
  endfunction

  function automatic req_t preload_beat(input logic [ADDR_W-1:0] idx,
                                        input logic signed [VAL_W-1:0] val);
    req_t r;
    r = '0;
    r.operation = OP_PRELOAD;
    r.entry_index = idx;
    r.entry_value = val;
    return r;
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    logic [WIN_W-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w = bin_floor($urandom_range(1, 7)) << $urandom_range(0, 1);
        w = w + 31'($urandom_range(0, 4)) - 31'd2;
      end
      4, 5, 6: w = 31'($urandom_range(0, 130000));
      7: w = 31'($urandom_range(0, 19999));
      8: w = 31'($urandom_range(120000, 32'h7FFF_FFFF));
      default: w = 31'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_entry();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 100)) - 50;
      1: v = '0;
      2: v = int'($urandom_range(0, 400000)) - 200000;
      default: v = $urandom;
    endcase
    if (v == 32'sh8000_0000) v = v + 1;
    return v;
  endfunction

  function automatic req_t random_beat();
    req_t r;
    r.operation = ($urandom_range(0, 99) < 18) ? OP_PRELOAD : OP_UPDATE;
    r.window_bytes = pick_window();
    r.random_draw = 8'($urandom_range(0, 255));
    r.random_action = 2'($urandom_range(0, 3));
    r.entry_index = 5'($urandom_range(0, 31));
    r.entry_value = pick_entry();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    fail_count++;
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TRAINING) train_en = data[0];
    else thr_level = data[THR_W-1:0];
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || req_valid || due_windows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic train, input logic [THR_W-1:0] thr,
                          input int send_pct, input int recv_pct);
    settle();
    cfg_write(REG_TRAINING, CFG_DATA_W'(train));
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr));
    send_gap_pct = send_pct;
    hold_off_pct = recv_pct;
  endtask

  task automatic random_phase(input logic train, input logic [THR_W-1:0] thr, input int n,
                              input int send_pct, input int recv_pct);
    set_mode(train, thr, send_pct, recv_pct);
    for (int i = 0; i < n; i++) begin
      req_backlog.push_back(random_beat());
      // Hold the sender off mid-phase until the block has drained.
      if (i == n / 2) settle();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        req <= req_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(0, 99) >= hold_off_pct);
  end

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (due_windows.size() == 0) begin
          report_mismatch("unexpected beat", rsp.new_window, '0);
        end else begin
          want = due_windows.pop_front();
          if (rsp.new_window !== want.new_window)
            report_mismatch("new_window", rsp.new_window, want.new_window);
          if (rsp.chosen_action !== want.chosen_action)
            report_mismatch("chosen_action", 32'(rsp.chosen_action), 32'(want.chosen_action));
          if (rsp.state_bin !== want.state_bin)
            report_mismatch("state_bin", 32'(rsp.state_bin), 32'(want.state_bin));
          if (rsp.explored !== want.explored)
            report_mismatch("explored", 32'(rsp.explored), 32'(want.explored));
        end
      end
      if (req_valid && req_ready) predict_window(req);
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_BINS * NUM_CHOICES; i++) value_tbl[i] = '0;
    send_gap_pct = 16;
    hold_off_pct = 78;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    req_backlog.push_back(preload_beat(5'd0, -32'sd2147483647));
    req_backlog.push_back(preload_beat(5'd1, 32'sd5));
    req_backlog.push_back(preload_beat(5'd2, 32'sd5));
    req_backlog.push_back(preload_beat(5'd3, -32'sd1));
    req_backlog.push_back(update_beat(31'd0, 8'd0, 2'd3));
    req_backlog.push_back(preload_beat(5'd7, 32'sd2147483647));
    req_backlog.push_back(update_beat(31'd29999, 8'd255, 2'd0));
    req_backlog.push_back(preload_beat(5'd10, 32'sd1));
    req_backlog.push_back(update_beat(31'd30000, 8'd0, 2'd1));
    req_backlog.push_back(update_beat(31'd19999, 8'd100, 2'd2));
    req_backlog.push_back(update_beat(31'h7FFF_FFFF, 8'd0, 2'd1));
    req_backlog.push_back(update_beat(31'd20000, 8'd0, 2'd0));
    req_backlog.push_back(update_beat(31'd59999, 8'd0, 2'd0));
    req_backlog.push_back(update_beat(31'd60000, 8'd0, 2'd0));
    req_backlog.push_back(update_beat(31'd119999, 8'd0, 2'd0));
    req_backlog.push_back(update_beat(31'd120000, 8'd0, 2'd0));
    req_backlog.push_back(preload_beat(5'd31, 32'sd2147483647));
    req_backlog.push_back(update_beat(31'd120001, 8'd0, 2'd0));

    set_mode(1'b1, 9'd256, 16, 78);
    req_backlog.push_back(update_beat(31'd40000, 8'd255, 2'd0));
    req_backlog.push_back(update_beat(31'd45000, 8'd255, 2'd1));
    req_backlog.push_back(update_beat(31'd50000, 8'd0, 2'd2));
    req_backlog.push_back(update_beat(31'd55000, 8'd128, 2'd3));

    random_phase(1'b1, EXPLORE_RESET, 200, 16, 78);
    random_phase(1'b1, 9'd256, 100, 16, 78);
    random_phase(1'b0, 9'd0, 150, 78, 16);
    random_phase(1'b1, 9'd0, 150, 78, 16);
    random_phase(1'b1, 9'($urandom_range(1, 255)), 150, 0, 0);
    random_phase(1'b1, EXPLORE_RESET, 150, 0, 0);

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== q_table_window_controller.f =====
src/qtwc_pkg.sv
src/qtwc_regs.sv
src/qtwc_table.sv
src/qtwc_core.sv
src/q_table_window_controller.sv
tb/q_table_window_controller_test.sv
